/* rtl/ssp_pkg.sv */
// Shared types and constants for the size string parser.
`timescale 1ns / 1ps
package ssp_pkg;

  localparam int unsigned OffsetBits  = 16;
  localparam int unsigned EndOffsetW  = 16;
  localparam int unsigned ValueW      = 64;
  localparam int unsigned QueueDepth  = 4;
  localparam int unsigned RadixW      = 5;
  localparam int unsigned ShiftW      = 6;

  localparam logic [7:0] CaseBit  = 8'h20;
  localparam logic [7:0] ChZero   = 8'h30;
  localparam logic [7:0] ChNine   = 8'h39;
  localparam logic [7:0] ChLowA   = 8'h61;
  localparam logic [7:0] ChLowF   = 8'h66;
  localparam logic [7:0] ChLowX   = 8'h78;
  localparam logic [7:0] ChLowK   = 8'h6b;
  localparam logic [7:0] ChLowM   = 8'h6d;
  localparam logic [7:0] ChLowG   = 8'h67;
  localparam logic [7:0] ChLowT   = 8'h74;
  localparam logic [7:0] ChLowP   = 8'h70;
  localparam logic [7:0] ChLowE   = 8'h65;

  localparam logic [RadixW-1:0] RadixOct = RadixW'(8);
  localparam logic [RadixW-1:0] RadixDec = RadixW'(10);
  localparam logic [RadixW-1:0] RadixHex = RadixW'(16);

  localparam logic [OffsetBits-1:0] OffsetMax = {OffsetBits{1'b1}};
  localparam logic [OffsetBits-1:0] HexStartPos = OffsetBits'(3);

  typedef logic [OffsetBits-1:0] pos_t;
  typedef logic [ValueW-1:0]     value_t;

  typedef struct packed {
    logic              first;
    logic              is_zero;
    logic              is_x;
    logic              is_hex;
    logic [3:0]        digit;
    logic [ShiftW-1:0] shift;
  } cls_t;

endpackage

/* rtl/ssp_if.sv */
// Request and result channel interfaces of the size string parser.
`timescale 1ns / 1ps
interface ssp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       first;

  modport source (output valid, output ch, output first, input ready);
  modport sink   (input valid, input ch, input first, output ready);
endinterface

interface ssp_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] value;
  logic [15:0] end_offset;

  modport source (output valid, output value, output end_offset, input ready);
  modport sink   (input valid, input value, input end_offset, output ready);
endinterface

/* rtl/ssp_front.sv */
// Front end: classify each character request and push it into the queue.
`timescale 1ns / 1ps
module ssp_front (
  ssp_in_if.sink         req_i,
  output ssp_pkg::cls_t  push_data_o,
  output logic           push_valid_o,
  input  logic           push_ready_i
);
  import ssp_pkg::*;

  logic [7:0] lower;
  logic       is_dec;
  logic       is_alpha_hex;

  assign lower        = req_i.ch | CaseBit;
  assign is_dec       = (req_i.ch >= ChZero) && (req_i.ch <= ChNine);
  assign is_alpha_hex = (lower >= ChLowA) && (lower <= ChLowF);

  always_comb begin
    push_data_o.first   = req_i.first;
    push_data_o.is_zero = (req_i.ch == ChZero);
    push_data_o.is_x    = (lower == ChLowX);
    push_data_o.is_hex  = is_dec || is_alpha_hex;
    if (is_dec) begin
      push_data_o.digit = 4'(req_i.ch - ChZero);
    end else if (is_alpha_hex) begin
      push_data_o.digit = 4'(lower - ChLowA + 8'd10);
    end else begin
      push_data_o.digit = '0;
    end
    unique case (lower)
      ChLowK:  push_data_o.shift = ShiftW'(10);
      ChLowM:  push_data_o.shift = ShiftW'(20);
      ChLowG:  push_data_o.shift = ShiftW'(30);
      ChLowT:  push_data_o.shift = ShiftW'(40);
      ChLowP:  push_data_o.shift = ShiftW'(50);
      ChLowE:  push_data_o.shift = ShiftW'(60);
      default: push_data_o.shift = '0;
    endcase
  end

  assign push_valid_o = req_i.valid;
  assign req_i.ready  = push_ready_i;

endmodule

/* rtl/ssp_queue.sv */
// Short queue of classified characters between front and back end.
`timescale 1ns / 1ps
module ssp_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  ssp_pkg::cls_t  push_data_i,
  input  logic           push_valid_i,
  output logic           push_ready_o,
  output ssp_pkg::cls_t  pop_data_o,
  output logic           pop_valid_o,
  input  logic           pop_ready_i
);
  import ssp_pkg::*;

  localparam int unsigned PtrW = $clog2(QueueDepth);
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  cls_t            mem_q [QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            push, pop;

  assign push_ready_o = (count_q != CntW'(QueueDepth));
  assign pop_valid_o  = (count_q != '0);
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

/* rtl/ssp_back.sv */
// Back end: parse state machine, accumulator and result register.
`timescale 1ns / 1ps
module ssp_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  ssp_pkg::cls_t  pop_data_i,
  input  logic           pop_valid_i,
  output logic           pop_ready_o,
  ssp_out_if.source      rsp_o
);
  import ssp_pkg::*;

  typedef enum logic [2:0] {
    PhIdle,
    PhZero,
    PhZeroX,
    PhDigits
  } phase_e;

  phase_e            phase_q, phase_d;
  logic [RadixW-1:0] radix_q, radix_d;
  value_t            acc_q, acc_d;
  pos_t              pos_q, pos_d;
  logic              out_valid_q, out_valid_d;
  value_t            out_value_q, out_value_d;
  pos_t              out_pos_q, out_pos_d;

  logic [RadixW-1:0] eff_radix;
  value_t            eff_acc;
  pos_t              eff_pos;
  pos_t              pos_inc;
  value_t            acc_mul;
  logic              step;
  logic              emit;
  logic              pop;

  assign pop_ready_o = !out_valid_q || rsp_o.ready;
  assign pop         = pop_valid_i && pop_ready_o;
  assign pos_inc     = (eff_pos == OffsetMax) ? eff_pos : eff_pos + 1'b1;

  always_comb begin
    eff_radix = radix_q;
    eff_acc   = acc_q;
    eff_pos   = pos_q;
    if (pop_data_i.first) begin
      eff_radix = RadixDec;
      eff_acc   = '0;
      eff_pos   = '0;
    end else if (phase_q == PhZero) begin
      eff_radix = RadixOct;
    end
  end

  always_comb begin
    unique case (eff_radix)
      RadixOct: acc_mul = eff_acc << 3;
      RadixHex: acc_mul = eff_acc << 4;
      default:  acc_mul = (eff_acc << 3) + (eff_acc << 1);
    endcase
  end

  always_comb begin
    phase_d     = phase_q;
    radix_d     = radix_q;
    acc_d       = acc_q;
    pos_d       = pos_q;
    step        = 1'b0;
    emit        = 1'b0;
    out_value_d = out_value_q;
    out_pos_d   = out_pos_q;

    if (pop) begin
      if (pop_data_i.first) begin
        if (pop_data_i.is_zero) begin
          acc_d   = '0;
          pos_d   = OffsetBits'(1);
          radix_d = RadixOct;
          phase_d = PhZero;
        end else begin
          step = 1'b1;
        end
      end else begin
        unique case (phase_q)
          PhZero: begin
            if (pop_data_i.is_x) begin
              phase_d = PhZeroX;
            end else begin
              step = 1'b1;
            end
          end
          PhZeroX: begin
            if (pop_data_i.is_hex) begin
              radix_d = RadixHex;
              acc_d   = ValueW'(pop_data_i.digit);
              pos_d   = HexStartPos;
              phase_d = PhDigits;
            end else begin
              acc_d       = '0;
              pos_d       = OffsetBits'(1);
              out_value_d = '0;
              out_pos_d   = OffsetBits'(1);
              emit        = 1'b1;
              phase_d     = PhIdle;
            end
          end
          PhDigits: step = 1'b1;
          default: ;
        endcase
      end

      if (step) begin
        radix_d = eff_radix;
        if (pop_data_i.is_hex && (RadixW'(pop_data_i.digit) < eff_radix)) begin
          acc_d   = acc_mul + ValueW'(pop_data_i.digit);
          pos_d   = pos_inc;
          phase_d = PhDigits;
        end else begin
          acc_d       = eff_acc << pop_data_i.shift;
          pos_d       = (pop_data_i.shift != '0) ? pos_inc : eff_pos;
          out_value_d = acc_d;
          out_pos_d   = pos_d;
          emit        = 1'b1;
          phase_d     = PhIdle;
        end
      end
    end

    if (emit) begin
      out_valid_d = 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PhIdle;
      radix_q     <= RadixDec;
      acc_q       <= '0;
      pos_q       <= '0;
      out_valid_q <= 1'b0;
      out_value_q <= '0;
      out_pos_q   <= '0;
    end else begin
      phase_q     <= phase_d;
      radix_q     <= radix_d;
      acc_q       <= acc_d;
      pos_q       <= pos_d;
      out_valid_q <= out_valid_d;
      out_value_q <= out_value_d;
      out_pos_q   <= out_pos_d;
    end
  end

  assign rsp_o.valid      = out_valid_q;
  assign rsp_o.value      = out_value_q;
  assign rsp_o.end_offset = EndOffsetW'(out_pos_q);

endmodule

/* rtl/size_string_parser_core.sv */
// Top level of the size string parser: front end, queue and back end.
`timescale 1ns / 1ps
// Takes one character request per cycle and parses size strings such as
// "0x1F", "0755" or "64k": a request with first set starts a new string,
// the base is taken from the prefix, and the first non-digit ends the
// number, with a k/m/g/t/p/e suffix shifting it left by 10 to 60 bits.
// One result (value, end_offset) follows each finished number. The block
// sustains one character per cycle while the queue has room; an accepted
// character is written into the queue, and a result that it finishes
// shows on rsp_o in the same cycle as the character, once popped, reaches
// the back end's parse registers. A four-entry queue between classification
// and parsing absorbs result-side stalls; req_i.ready drops only when it fills.
module size_string_parser_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  ssp_in_if.sink     req_i,
  ssp_out_if.source  rsp_o
);
  import ssp_pkg::*;

  cls_t push_data;
  logic push_valid;
  logic push_ready;
  cls_t pop_data;
  logic pop_valid;
  logic pop_ready;

  ssp_front u_front (
    .req_i        (req_i),
    .push_data_o  (push_data),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready)
  );

  ssp_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_data_i  (push_data),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .pop_data_o   (pop_data),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready)
  );

  ssp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_data_i  (pop_data),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .rsp_o       (rsp_o)
  );

endmodule
